>>> sv/ppe_pkg.sv
// Package for the particle pool engine.
// Holds operation codes, controller state codes and the command/status structs.
// No dependencies.
package ppe_pkg;

  typedef enum logic [1:0] {
    FUNC_EMIT  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_EM_SCAN = 10'b0000000010,
    ST_EM_WR   = 10'b0000000100,
    ST_TK_SCAN = 10'b0000001000,
    ST_TK_LIFE = 10'b0000010000,
    ST_TK_MUL  = 10'b0000100000,
    ST_TK_DIV  = 10'b0001000000,
    ST_TK_WR   = 10'b0010000000,
    ST_RD_SCAN = 10'b0100000000,
    ST_RD_LOAD = 10'b1000000000
  } state_t;

  localparam int AXES      = 3;
  localparam int DIV_BITS  = 8;
  localparam int REM_W     = 39;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       wr_emit;
    logic       kill;
    logic       life_chk;
    logic       mul;
    logic       add;
    logic [1:0] ax;
    logic       div_step;
    logic [2:0] dbit;
    logic       wr_tick;
    logic       out_load;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic live_bit;
    logic later_any;
    logic expired;
  } sts_t;

endpackage

>>> sv/ppe_datapath.sv
// Datapath of the particle pool engine: slot memories, live bits, motion,
// alpha divider and result register.
// Depends on ppe_pkg.
module ppe_datapath #(
  parameter int POOL_SLOTS = 64,
  parameter int IW = $clog2(POOL_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppe_pkg::cmd_t       cmd,
  input  logic [IW-1:0]       addr,
  output ppe_pkg::sts_t       sts,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_vel_x,
  input  logic signed [31:0]  in_vel_y,
  input  logic signed [31:0]  in_vel_z,
  input  logic [31:0]         in_color_rgba,
  input  logic [30:0]         in_life,
  input  logic [31:0]         in_size,
  input  logic [30:0]         in_dt,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic [31:0]         out_color_rgba,
  output logic [31:0]         out_size,
  output logic                out_last_in_run
);
  import ppe_pkg::*;

  logic [31:0] px_mem [POOL_SLOTS];
  logic [31:0] py_mem [POOL_SLOTS];
  logic [31:0] pz_mem [POOL_SLOTS];
  logic [31:0] vx_mem [POOL_SLOTS];
  logic [31:0] vy_mem [POOL_SLOTS];
  logic [31:0] vz_mem [POOL_SLOTS];
  logic [31:0] col_mem [POOL_SLOTS];
  logic [30:0] life_mem [POOL_SLOTS];
  logic [30:0] full_mem [POOL_SLOTS];
  logic [31:0] size_mem [POOL_SLOTS];

  logic [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r, col_r, size_r;
  logic [30:0] life_r, full_r;
  logic [31:0] ipx_r, ipy_r, ipz_r, ivx_r, ivy_r, ivz_r, icol_r, isize_r;
  logic [30:0] ilife_r, dt_r, newlife_r;
  logic [POOL_SLOTS-1:0] live_r;
  logic signed [63:0] prod_r;
  logic [31:0] newpos_r [AXES];
  logic [REM_W-1:0] rem_r;
  logic [DIV_BITS-1:0] alpha_r;

  logic signed [31:0] vsel, psel;
  logic signed [47:0] step;
  logic signed [48:0] sum;
  logic [31:0] sat;
  logic [REM_W-1:0] dsh;
  logic [POOL_SLOTS-1:0] later;

  always_ff @(posedge clk) begin
    px_r   <= px_mem[addr];
    py_r   <= py_mem[addr];
    pz_r   <= pz_mem[addr];
    vx_r   <= vx_mem[addr];
    vy_r   <= vy_mem[addr];
    vz_r   <= vz_mem[addr];
    col_r  <= col_mem[addr];
    life_r <= life_mem[addr];
    full_r <= full_mem[addr];
    size_r <= size_mem[addr];
    if (cmd.wr_emit) begin
      px_mem[addr]   <= ipx_r;
      py_mem[addr]   <= ipy_r;
      pz_mem[addr]   <= ipz_r;
      vx_mem[addr]   <= ivx_r;
      vy_mem[addr]   <= ivy_r;
      vz_mem[addr]   <= ivz_r;
      col_mem[addr]  <= icol_r;
      life_mem[addr] <= ilife_r;
      full_mem[addr] <= ilife_r;
      size_mem[addr] <= isize_r;
    end else if (cmd.wr_tick) begin
      px_mem[addr]   <= newpos_r[0];
      py_mem[addr]   <= newpos_r[1];
      pz_mem[addr]   <= newpos_r[2];
      col_mem[addr]  <= {col_r[31:8], alpha_r};
      life_mem[addr] <= newlife_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cmd.clear) begin
      live_r <= '0;
    end else if (cmd.wr_emit) begin
      live_r[addr] <= (ilife_r != '0);
    end else if (cmd.kill) begin
      live_r[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ipx_r   <= in_pos_x;
      ipy_r   <= in_pos_y;
      ipz_r   <= in_pos_z;
      ivx_r   <= in_vel_x;
      ivy_r   <= in_vel_y;
      ivz_r   <= in_vel_z;
      icol_r  <= in_color_rgba;
      ilife_r <= in_life;
      isize_r <= in_size;
      dt_r    <= in_dt;
    end
  end

  always_comb begin
    unique case (cmd.ax)
      2'd0:    vsel = vx_r;
      2'd1:    vsel = vy_r;
      default: vsel = vz_r;
    endcase
    unique case (cmd.ax)
      2'd1:    psel = px_r;
      2'd2:    psel = py_r;
      default: psel = pz_r;
    endcase
    step = prod_r[63:16];
    sum  = {{17{psel[31]}}, psel} + {step[47], step};
    if (sum[48:31] == '0 || sum[48:31] == '1) begin
      sat = sum[31:0];
    end else if (sum[48]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
    dsh = {8'd0, full_r} << cmd.dbit;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      later[i] = live_r[i] && (i > int'(addr));
    end
  end

  assign sts.live_bit  = live_r[addr];
  assign sts.later_any = |later;
  assign sts.expired   = (life_r <= dt_r);

  always_ff @(posedge clk) begin
    if (cmd.life_chk) begin
      newlife_r <= life_r - dt_r;
      rem_r     <= ({8'd0, life_r - dt_r} << 8) - {8'd0, life_r - dt_r};
      alpha_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        alpha_r[cmd.dbit] <= 1'b1;
      end
    end
    if (cmd.mul) begin
      prod_r <= vsel * $signed({1'b0, dt_r});
    end
    if (cmd.add) begin
      newpos_r[cmd.ax - 2'd1] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_x       <= px_r;
      out_pos_y       <= py_r;
      out_pos_z       <= pz_r;
      out_color_rgba  <= col_r;
      out_size        <= size_r;
      out_last_in_run <= cmd.out_last;
    end
  end

endmodule

>>> sv/ppe_ctrl.sv
// Controller of the particle pool engine: operation sequencing, slot walk,
// rover and result handshake.
// Depends on ppe_pkg.
module ppe_ctrl #(
  parameter int POOL_SLOTS = 64,
  parameter int IW = $clog2(POOL_SLOTS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_func,
  output logic           out_valid,
  input  logic           out_ready,
  output ppe_pkg::cmd_t  cmd,
  output logic [IW-1:0]  addr,
  input  ppe_pkg::sts_t  sts
);
  import ppe_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(POOL_SLOTS - 1);

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt, rover_r, rover_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, room;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign addr      = idx_r;
  assign room      = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    rover_nxt     = rover_r;
    ax_nxt        = ax_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.ax        = ax_r;
    cmd.dbit      = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (func_t'(in_func))
            FUNC_EMIT: begin
              idx_nxt   = rover_r;
              cnt_nxt   = '0;
              state_nxt = ST_EM_SCAN;
            end
            FUNC_TICK: begin
              idx_nxt   = '0;
              state_nxt = ST_TK_SCAN;
            end
            FUNC_CLEAR: begin
              cmd.clear = 1'b1;
              rover_nxt = '0;
            end
            default: begin
              idx_nxt   = '0;
              state_nxt = ST_RD_SCAN;
            end
          endcase
        end
      end
      ST_EM_SCAN: begin
        if (!sts.live_bit) begin
          rover_nxt = idx_r;
          state_nxt = ST_EM_WR;
        end else if (cnt_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_EM_WR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = (idx_r == LAST) ? '0 : idx_r + 1'b1;
        end
      end
      ST_EM_WR: begin
        cmd.wr_emit = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_TK_SCAN: begin
        if (sts.live_bit) begin
          state_nxt = ST_TK_LIFE;
        end else if (idx_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TK_LIFE: begin
        if (sts.expired) begin
          cmd.kill  = 1'b1;
          state_nxt = (idx_r == LAST) ? ST_IDLE : ST_TK_SCAN;
          idx_nxt   = (idx_r == LAST) ? idx_r : idx_r + 1'b1;
        end else begin
          cmd.life_chk = 1'b1;
          ax_nxt       = 2'd0;
          state_nxt    = ST_TK_MUL;
        end
      end
      ST_TK_MUL: begin
        cmd.mul = (ax_r != 2'd3);
        cmd.add = (ax_r != 2'd0);
        ax_nxt  = ax_r + 2'd1;
        if (ax_r == 2'd3) begin
          bit_nxt   = 3'd7;
          state_nxt = ST_TK_DIV;
        end
      end
      ST_TK_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = ST_TK_WR;
        end
      end
      ST_TK_WR: begin
        cmd.wr_tick = 1'b1;
        state_nxt   = (idx_r == LAST) ? ST_IDLE : ST_TK_SCAN;
        idx_nxt     = (idx_r == LAST) ? idx_r : idx_r + 1'b1;
      end
      ST_RD_SCAN: begin
        if (sts.live_bit) begin
          state_nxt = ST_RD_LOAD;
        end else if (idx_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RD_LOAD: begin
        if (room) begin
          cmd.out_load  = 1'b1;
          cmd.out_last  = !sts.later_any;
          out_valid_nxt = 1'b1;
          state_nxt     = (idx_r == LAST) ? ST_IDLE : ST_RD_SCAN;
          idx_nxt       = (idx_r == LAST) ? idx_r : idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      rover_r     <= '0;
      ax_r        <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      rover_r     <= rover_nxt;
      ax_r        <= ax_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/particle_pool_engine_unit.sv
// Top level of the particle pool engine.
// Depends on ppe_pkg, ppe_ctrl and ppe_datapath.
//
// Usage: one input channel (in_valid/in_ready) carries requests selected by
// in_func: emit, tick, clear or readout. One result channel
// (out_valid/out_ready) carries one transaction per live particle during a
// readout, in slot order, with out_last_in_run on the final one. A readout
// with no live particle gives no transaction.
// Emit searches for a free slot from the rover, one slot per cycle; tick
// walks every slot and, per surviving particle, uses the shared multiplier
// (one axis a cycle) and the 8-step alpha divider; readout walks every slot
// through the single memory read port and holds while the receiver stalls.
// Requests are taken one at a time; in_ready is high while the engine idles.
// A result waits in the output register while out_ready is low; the walk
// holds until it is taken, and a new request may be taken meanwhile.
// Reset kills every slot and returns the rover to slot 0; no clearing pass.
module particle_pool_engine_unit #(
  parameter int POOL_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [31:0]        in_color_rgba,
  input  logic [30:0]        in_life,
  input  logic [31:0]        in_size,
  input  logic [30:0]        in_dt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic [31:0]        out_color_rgba,
  output logic [31:0]        out_size,
  output logic               out_last_in_run
);
  import ppe_pkg::*;

  localparam int IW = $clog2(POOL_SLOTS);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] addr;

  ppe_ctrl #(.POOL_SLOTS(POOL_SLOTS), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .addr      (addr),
    .sts       (sts)
  );

  ppe_datapath #(.POOL_SLOTS(POOL_SLOTS), .IW(IW)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .sts             (sts),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_color_rgba   (in_color_rgba),
    .in_life         (in_life),
    .in_size         (in_size),
    .in_dt           (in_dt),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_color_rgba  (out_color_rgba),
    .out_size        (out_size),
    .out_last_in_run (out_last_in_run)
  );

endmodule

>>> sv/ppe_checker.sv
// Port-level checks for the particle pool engine, bound to the top level.
// Depends on ppe_pkg and particle_pool_engine_unit.
module ppe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic        out_last_in_run
);
  import ppe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x)
      && $stable(out_last_in_run))
    else $error("result changed while stalled");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_EMIT |=> !in_ready)
    else $error("emit finished without a slot search");

  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_CLEAR |=> in_ready)
    else $error("clear did not complete in one cycle");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind particle_pool_engine_unit ppe_checker u_ppe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pos_x       (out_pos_x),
  .out_last_in_run (out_last_in_run)
);

>>> verif/particle_pool_engine_unit_test.sv
// Self-checking testbench for particle_pool_engine_unit: emit, tick, clear and
// readout requests; readouts checked against an in-bench particle predictor.
// Depends on ppe_pkg and the particle_pool_engine_unit RTL.
`timescale 1ns / 100ps

module particle_pool_engine_unit_test;
  import ppe_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] px, py, pz, color, size;
    logic        last;
  } particle_view_t;

  class pool_scoreboard;
    logic [31:0] px[SLOTS], py[SLOTS], pz[SLOTS];
    logic [31:0] vx[SLOTS], vy[SLOTS], vz[SLOTS];
    logic [31:0] color[SLOTS], size[SLOTS];
    logic [30:0] life_left[SLOTS], full_life[SLOTS];
    int unsigned rover;
    particle_view_t pending[$];
    int errors;

    function new();
      rover = 0;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) life_left[i] = '0;
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (life_left[i] != 0) n++;
      return n;
    endfunction

    function logic [31:0] move(logic [31:0] p, logic [31:0] v, logic [30:0] dt);
      longint prod, stp, sum;
      prod = longint'($signed(v)) * longint'({1'b0, dt});
      stp = prod >>> 16;
      sum = longint'($signed(p)) + stp;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
    endfunction

    function void note_request(logic [1:0] fn, logic [31:0] ipx, logic [31:0] ipy,
                               logic [31:0] ipz, logic [31:0] ivx, logic [31:0] ivy,
                               logic [31:0] ivz, logic [31:0] icol, logic [30:0] ilife,
                               logic [31:0] isize, logic [30:0] idt);
      int s, n;
      logic [63:0] a;
      particle_view_t r;
      case (fn)
        FUNC_EMIT: begin
          s = -1;
          for (int i = rover; i < SLOTS && s < 0; i++) if (life_left[i] == 0) s = i;
          for (int i = 0; i < rover && s < 0; i++) if (life_left[i] == 0) s = i;
          if (s < 0) s = 0;
          else rover = s;
          px[s] = ipx; py[s] = ipy; pz[s] = ipz;
          vx[s] = ivx; vy[s] = ivy; vz[s] = ivz;
          color[s] = icol; size[s] = isize;
          life_left[s] = ilife; full_life[s] = ilife;
        end
        FUNC_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (life_left[i] == 0) continue;
            if (life_left[i] <= idt) begin
              life_left[i] = '0;
              continue;
            end
            life_left[i] = life_left[i] - idt;
            px[i] = move(px[i], vx[i], idt);
            py[i] = move(py[i], vy[i], idt);
            pz[i] = move(pz[i], vz[i], idt);
            if (full_life[i] == 0) a = 255;
            else a = (64'(life_left[i]) * 255) / 64'(full_life[i]);
            if (a > 255) a = 255;
            color[i] = {color[i][31:8], a[7:0]};
          end
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) life_left[i] = '0;
          rover = 0;
        end
        default: begin
          n = live_count();
          for (int i = 0; i < SLOTS; i++) begin
            if (life_left[i] == 0) continue;
            n--;
            r.px = px[i]; r.py = py[i]; r.pz = pz[i];
            r.color = color[i]; r.size = size[i]; r.last = (n == 0);
            pending.push_back(r);
          end
        end
      endcase
    endfunction

    task check_particle(particle_view_t got);
      particle_view_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected particle transaction");
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) report_mismatch($sformatf("pos_x %h exp %h", got.px, e.px));
      if (got.py !== e.py) report_mismatch($sformatf("pos_y %h exp %h", got.py, e.py));
      if (got.pz !== e.pz) report_mismatch($sformatf("pos_z %h exp %h", got.pz, e.pz));
      if (got.color !== e.color)
        report_mismatch($sformatf("color %h exp %h", got.color, e.color));
      if (got.size !== e.size) report_mismatch($sformatf("size %h exp %h", got.size, e.size));
      if (got.last !== e.last) report_mismatch($sformatf("last %b exp %b", got.last, e.last));
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_func;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [31:0] in_color_rgba, in_size;
  logic [30:0] in_life, in_dt;
  logic out_valid, out_ready;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [31:0] out_color_rgba, out_size;
  logic out_last_in_run;

  pool_scoreboard board = new();
  int send_idle_pct, recv_idle_pct;
  int cycles;

  particle_pool_engine_unit dut (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
    in_func = FUNC_EMIT;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_vel_x = '0; in_vel_y = '0; in_vel_z = '0;
    in_color_rgba = '0; in_life = '0; in_size = '0; in_dt = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_particle('{out_pos_x, out_pos_y, out_pos_z, out_color_rgba,
                               out_size, out_last_in_run});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [1:0] fn, logic [31:0] ipx, logic [31:0] ipy,
                              logic [31:0] ipz, logic [31:0] ivx, logic [31:0] ivy,
                              logic [31:0] ivz, logic [31:0] icol, logic [30:0] ilife,
                              logic [31:0] isize, logic [30:0] idt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_pos_x <= ipx; in_pos_y <= ipy; in_pos_z <= ipz;
    in_vel_x <= ivx; in_vel_y <= ivy; in_vel_z <= ivz;
    in_color_rgba <= icol; in_life <= ilife; in_size <= isize; in_dt <= idt;
    do @(posedge clk); while (!in_ready);
    board.note_request(fn, ipx, ipy, ipz, ivx, ivy, ivz, icol, ilife, isize, idt);
  endtask

  task automatic send_emit(logic [30:0] ilife);
    send_request(FUNC_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, ilife, $urandom, 31'($urandom));
  endtask

  task automatic send_op(logic [1:0] fn, logic [30:0] idt);
    send_request(fn, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, 31'($urandom), $urandom, idt);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_life();
    case ($urandom_range(5))
      0: return 31'd1;
      1: return 31'h7FFFFFFF;
      2: return '0;
      default: return 31'($urandom_range(32'h00200000, 32'h00010000));
    endcase
  endfunction

  function automatic logic [30:0] pick_dt();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom);
      default: return 31'($urandom_range(32'h00008000, 32'h00000100));
    endcase
  endfunction

  task automatic random_phase(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: send_emit(pick_life());
        9, 10, 11, 12: send_op(FUNC_TICK, pick_dt());
        13: send_op(FUNC_CLEAR, 31'($urandom));
        default: send_op(FUNC_READ, 31'($urandom));
      endcase
    end
  endtask

  initial begin
    cycles = 0;
    send_idle_pct = 17;
    recv_idle_pct = 52;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(FUNC_READ, '0);
    send_request(FUNC_EMIT, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF,
                 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, '0);
    send_request(FUNC_EMIT, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 32'h80000000,
                 32'h7FFFFFFF, 32'h00000001, 32'h0, 31'h00010000, 32'h0, '0);
    send_emit('0);
    send_emit(31'd1);
    send_op(FUNC_READ, '0);
    send_op(FUNC_TICK, 31'h00004000);
    send_op(FUNC_READ, '0);
    send_op(FUNC_TICK, 31'h7FFFFFFF);
    send_op(FUNC_READ, '0);
    for (int i = 0; i < SLOTS + 2; i++) send_emit(31'h7FFFFFFF);
    send_op(FUNC_READ, '0);
    send_op(FUNC_TICK, 31'h00000001);
    send_op(FUNC_CLEAR, '0);
    send_op(FUNC_READ, '0);

    random_phase(84);
    drain_results();
    send_idle_pct = 52;
    recv_idle_pct = 17;
    random_phase(84);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(84);

    drain_results();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/ppe_pkg.sv
sv/ppe_datapath.sv
sv/ppe_ctrl.sv
sv/particle_pool_engine_unit.sv
sv/ppe_checker.sv
verif/particle_pool_engine_unit_test.sv
